/* rtl/hvpss_pkg.sv */
package hvpss_pkg;

  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned PRE_TICKS        = 8;
  localparam int unsigned PULL_IN_TICKS    = 6;
  localparam int unsigned AVG_SAMPLES      = 10;
  localparam int unsigned FAIL_HOLD_TICKS  = 10;
  localparam int unsigned ZERO_WAIT_TICKS  = 5;
  localparam int unsigned STOP_DELAY_TICKS = 2;

  localparam int unsigned VOLT_W      = 12;
  localparam int unsigned CUR_W       = 12;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned TICK_W      = 7;
  localparam int unsigned DUTY_W      = 4;
  localparam int unsigned MSG_W       = 5;
  localparam int unsigned LIMIT_W     = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned MSG_SLOTS   = 3;
  localparam int unsigned MSG_CNT_W   = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // sum / AVG_SAMPLES as multiply by rounded-up reciprocal and shift
  localparam int unsigned DIV_SHIFT  = 21;
  localparam int unsigned DIV_MULT_W = 22;
  localparam int unsigned PROD_W     = SUM_W + DIV_MULT_W;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'((2**DIV_SHIFT + AVG_SAMPLES - 1) / AVG_SAMPLES);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BUS_VOLTS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_RISE_VOLTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_DELTA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULL_IN_DUTY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUTY      = 3'd5;

  localparam logic [VOLT_W-1:0]  RST_MIN_BUS_VOLTS  = 12'd2200;
  localparam logic [VOLT_W-1:0]  RST_PRE_RISE_VOLTS = 12'd600;
  localparam logic [VOLT_W-1:0]  RST_SETTLE_DELTA   = 12'd50;
  localparam logic [LIMIT_W-1:0] RST_SETTLE_LIMIT   = 7'd60;
  localparam logic [DUTY_W-1:0]  RST_PULL_IN_DUTY   = 4'd10;
  localparam logic [DUTY_W-1:0]  RST_HOLD_DUTY      = 4'd4;

  localparam logic [MSG_W-1:0] MSG_NONE         = 5'd0;
  localparam logic [MSG_W-1:0] MSG_WAVE_OFF     = 5'd0;
  localparam logic [MSG_W-1:0] MSG_CHECK_OIL    = 5'd1;
  localparam logic [MSG_W-1:0] MSG_ZERO_VOLTS   = 5'd2;
  localparam logic [MSG_W-1:0] MSG_PRECHARGE    = 5'd3;
  localparam logic [MSG_W-1:0] MSG_HV_ON        = 5'd4;
  localparam logic [MSG_W-1:0] MSG_ZERO_AMPS    = 5'd5;
  localparam logic [MSG_W-1:0] MSG_ZERO_THROT   = 5'd8;
  localparam logic [MSG_W-1:0] MSG_WAVE_ON      = 5'd9;
  localparam logic [MSG_W-1:0] MSG_OIL_FAULT    = 5'd11;
  localparam logic [MSG_W-1:0] MSG_READY        = 5'd13;
  localparam logic [MSG_W-1:0] MSG_OIL_OFF      = 5'd16;
  localparam logic [MSG_W-1:0] MSG_HV_OFF       = 5'd17;
  localparam logic [MSG_W-1:0] MSG_BLANK        = 5'd19;
  localparam logic [MSG_W-1:0] MSG_PRE_PRE_FAIL = 5'd20;
  localparam logic [MSG_W-1:0] MSG_PRE_FAIL     = 5'd21;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_FAULT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_SETTLE,
    PH_PULLIN,
    PH_ZERO,
    PH_ANNOUNCE,
    PH_FAILHOLD,
    PH_STOPWAIT
  } phase_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_FAULTED = 2'd2
  } status_t;

  typedef enum logic {
    SQ_EXEC,
    SQ_POST
  } sq_state_t;

  typedef struct packed {
    mode_t             kind;
    logic [VOLT_W-1:0] volts;
    logic [CUR_W-1:0]  current;
    logic              oil_ok;
  } item_t;

  typedef struct packed {
    status_t                          status;
    logic                             busy;
    logic                             relay;
    logic [DUTY_W-1:0]                duty;
    logic                             pwm;
    logic [VOLT_W-1:0]                volt_zero;
    logic [CUR_W-1:0]                 current_zero;
    logic [MSG_CNT_W-1:0]             msg_count;
    logic [MSG_SLOTS-1:0][MSG_W-1:0]  msg_codes;
  } rec_t;

endpackage

/* rtl/hvpss_front.sv */
module hvpss_front #(
  parameter int unsigned DEPTH = hvpss_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [hvpss_pkg::VOLT_W-1:0]  in_bus_volts,
  input  logic [hvpss_pkg::CUR_W-1:0]   in_bus_current,
  input  logic                          in_oil_switch_ok,
  output logic                          q_valid,
  input  logic                          q_ready,
  output hvpss_pkg::item_t              q_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hvpss_pkg::item_t   slot_r [DEPTH];
  hvpss_pkg::item_t   item_in;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop;

  // classify the command
  always_comb begin
    unique case (in_mode)
      hvpss_pkg::MODE_TICK:  item_in.kind = hvpss_pkg::MODE_TICK;
      hvpss_pkg::MODE_START: item_in.kind = hvpss_pkg::MODE_START;
      hvpss_pkg::MODE_STOP:  item_in.kind = hvpss_pkg::MODE_STOP;
      default:               item_in.kind = hvpss_pkg::MODE_FAULT;
    endcase
    item_in.volts   = in_bus_volts;
    item_in.current = in_bus_current;
    item_in.oil_ok  = in_oil_switch_ok;
  end

  assign in_ready = (count_r != CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* rtl/hvpss_seq.sv */
module hvpss_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hvpss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hvpss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  hvpss_pkg::item_t                  item,
  output logic                              rec_valid,
  input  logic                              rec_ready,
  output hvpss_pkg::rec_t                   rec
);

  localparam int unsigned VW = hvpss_pkg::VOLT_W;
  localparam int unsigned TW = hvpss_pkg::TICK_W;

  // configuration
  logic [VW-1:0]                    min_bus_r, pre_rise_r, settle_delta_r;
  logic [hvpss_pkg::LIMIT_W-1:0]    settle_limit_r;
  logic [hvpss_pkg::DUTY_W-1:0]     pull_in_duty_r, hold_duty_r;

  // sequence state
  hvpss_pkg::sq_state_t             sq_r, sq_nxt;
  hvpss_pkg::phase_t                phase_r, phase_nxt;
  hvpss_pkg::status_t               status_r, status_nxt;
  logic [TW-1:0]                    tick_r, tick_nxt, tick_inc;
  logic                             charged_r, charged_nxt;
  logic [VW-1:0]                    ref_volts_r, ref_volts_nxt;
  logic [VW-1:0]                    prev_volts_r, prev_volts_nxt;
  logic [hvpss_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [VW-1:0]                    volt_zero_r, volt_zero_nxt;
  logic [hvpss_pkg::CUR_W-1:0]      cur_zero_r, cur_zero_nxt;
  logic [hvpss_pkg::DUTY_W-1:0]     duty_r, duty_nxt;
  logic                             relay_r, relay_nxt;
  logic                             pwm_r, pwm_nxt;

  logic [hvpss_pkg::MSG_SLOTS-1:0][hvpss_pkg::MSG_W-1:0] msg_r, msg_nxt;
  logic [hvpss_pkg::MSG_CNT_W-1:0]  msg_cnt_r, msg_cnt_nxt;
  logic                             div_pend_r, div_pend_nxt;

  logic                             take;
  logic signed [VW:0]               rise, step;
  logic [hvpss_pkg::PROD_W-1:0]     prod;
  logic [hvpss_pkg::CUR_W-1:0]      quot;

  assign item_ready = (sq_r == hvpss_pkg::SQ_EXEC);
  assign take       = item_valid && item_ready;
  assign tick_inc   = tick_r + 1'b1;
  assign rise       = $signed({1'b0, item.volts}) - $signed({1'b0, ref_volts_r});
  assign step       = $signed({1'b0, item.volts}) - $signed({1'b0, prev_volts_r});

  assign prod = hvpss_pkg::PROD_W'(sum_r) * hvpss_pkg::PROD_W'(hvpss_pkg::DIV_MULT);
  assign quot = prod[hvpss_pkg::DIV_SHIFT +: hvpss_pkg::CUR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bus_r      <= hvpss_pkg::RST_MIN_BUS_VOLTS;
      pre_rise_r     <= hvpss_pkg::RST_PRE_RISE_VOLTS;
      settle_delta_r <= hvpss_pkg::RST_SETTLE_DELTA;
      settle_limit_r <= hvpss_pkg::RST_SETTLE_LIMIT;
      pull_in_duty_r <= hvpss_pkg::RST_PULL_IN_DUTY;
      hold_duty_r    <= hvpss_pkg::RST_HOLD_DUTY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hvpss_pkg::CFG_MIN_BUS_VOLTS:  min_bus_r      <= cfg_wdata;
        hvpss_pkg::CFG_PRE_RISE_VOLTS: pre_rise_r     <= cfg_wdata;
        hvpss_pkg::CFG_SETTLE_DELTA:   settle_delta_r <= cfg_wdata;
        hvpss_pkg::CFG_SETTLE_LIMIT:   settle_limit_r <= cfg_wdata[hvpss_pkg::LIMIT_W-1:0];
        hvpss_pkg::CFG_PULL_IN_DUTY:   pull_in_duty_r <= cfg_wdata[hvpss_pkg::DUTY_W-1:0];
        hvpss_pkg::CFG_HOLD_DUTY:      hold_duty_r    <= cfg_wdata[hvpss_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sq_nxt         = sq_r;
    phase_nxt      = phase_r;
    status_nxt     = status_r;
    tick_nxt       = tick_r;
    charged_nxt    = charged_r;
    ref_volts_nxt  = ref_volts_r;
    prev_volts_nxt = prev_volts_r;
    sum_nxt        = sum_r;
    volt_zero_nxt  = volt_zero_r;
    cur_zero_nxt   = cur_zero_r;
    duty_nxt       = duty_r;
    relay_nxt      = relay_r;
    pwm_nxt        = pwm_r;
    msg_nxt        = msg_r;
    msg_cnt_nxt    = msg_cnt_r;
    div_pend_nxt   = div_pend_r;
    rec_valid      = 1'b0;

    rec.status       = status_r;
    rec.busy         = (phase_r != hvpss_pkg::PH_IDLE);
    rec.relay        = relay_r;
    rec.duty         = duty_r;
    rec.pwm          = pwm_r;
    rec.volt_zero    = volt_zero_r;
    rec.current_zero = div_pend_r ? quot : cur_zero_r;
    rec.msg_count    = msg_cnt_r;
    rec.msg_codes    = msg_r;

    unique case (sq_r)
      hvpss_pkg::SQ_EXEC: begin
        if (take) begin
          sq_nxt       = hvpss_pkg::SQ_POST;
          msg_cnt_nxt  = '0;
          msg_nxt      = '0;
          div_pend_nxt = 1'b0;
          unique case (item.kind)
            hvpss_pkg::MODE_TICK: begin
              unique case (phase_r)
                hvpss_pkg::PH_PRE: begin
                  tick_nxt = tick_inc;
                  if (tick_inc >= TW'(hvpss_pkg::PRE_TICKS)) begin
                    tick_nxt = '0;
                    if (rise > $signed({1'b0, pre_rise_r})) begin
                      phase_nxt      = hvpss_pkg::PH_SETTLE;
                      prev_volts_nxt = item.volts;
                    end else begin
                      relay_nxt   = 1'b0;
                      duty_nxt    = '0;
                      status_nxt  = hvpss_pkg::ST_FAULTED;
                      msg_nxt[0]  = hvpss_pkg::MSG_PRE_PRE_FAIL;
                      msg_cnt_nxt = 2'd1;
                      phase_nxt   = hvpss_pkg::PH_FAILHOLD;
                    end
                  end
                end
                hvpss_pkg::PH_SETTLE: begin
                  if (item.volts > min_bus_r && step < $signed({1'b0, settle_delta_r})) begin
                    msg_nxt[0]  = hvpss_pkg::MSG_HV_ON;
                    msg_cnt_nxt = 2'd1;
                    duty_nxt    = pull_in_duty_r;
                    phase_nxt   = hvpss_pkg::PH_PULLIN;
                    tick_nxt    = '0;
                  end else if (tick_r > settle_limit_r || tick_r == hvpss_pkg::TICK_MAX) begin
                    relay_nxt   = 1'b0;
                    duty_nxt    = '0;
                    status_nxt  = hvpss_pkg::ST_FAULTED;
                    msg_nxt[0]  = hvpss_pkg::MSG_PRE_FAIL;
                    msg_cnt_nxt = 2'd1;
                    phase_nxt   = hvpss_pkg::PH_FAILHOLD;
                    tick_nxt    = '0;
                  end else begin
                    tick_nxt       = tick_inc;
                    prev_volts_nxt = item.volts;
                  end
                end
                hvpss_pkg::PH_PULLIN: begin
                  tick_nxt = tick_inc;
                  if (tick_inc >= TW'(hvpss_pkg::PULL_IN_TICKS)) begin
                    duty_nxt    = hold_duty_r;
                    charged_nxt = 1'b1;
                    relay_nxt   = 1'b1;
                    msg_nxt[0]  = hvpss_pkg::MSG_ZERO_AMPS;
                    msg_cnt_nxt = 2'd1;
                    phase_nxt   = hvpss_pkg::PH_ZERO;
                    tick_nxt    = '0;
                    sum_nxt     = '0;
                  end
                end
                hvpss_pkg::PH_ZERO: begin
                  tick_nxt = tick_inc;
                  if (tick_inc > TW'(hvpss_pkg::ZERO_WAIT_TICKS)) begin
                    sum_nxt = sum_r + hvpss_pkg::SUM_W'(item.current);
                    if (tick_inc >= TW'(hvpss_pkg::ZERO_WAIT_TICKS + hvpss_pkg::AVG_SAMPLES))
                    begin
                      div_pend_nxt = 1'b1;
                      msg_nxt[0]   = hvpss_pkg::MSG_ZERO_THROT;
                      msg_nxt[1]   = hvpss_pkg::MSG_WAVE_ON;
                      msg_cnt_nxt  = 2'd2;
                      status_nxt   = hvpss_pkg::ST_RUNNING;
                      pwm_nxt      = 1'b1;
                      phase_nxt    = hvpss_pkg::PH_ANNOUNCE;
                      tick_nxt     = '0;
                    end
                  end
                end
                hvpss_pkg::PH_ANNOUNCE: begin
                  msg_nxt[0]  = hvpss_pkg::MSG_READY;
                  msg_nxt[1]  = hvpss_pkg::MSG_BLANK;
                  msg_cnt_nxt = 2'd2;
                  phase_nxt   = hvpss_pkg::PH_IDLE;
                  tick_nxt    = '0;
                end
                hvpss_pkg::PH_FAILHOLD: begin
                  tick_nxt = tick_inc;
                  if (tick_inc >= TW'(hvpss_pkg::FAIL_HOLD_TICKS)) begin
                    msg_nxt[0]  = hvpss_pkg::MSG_BLANK;
                    msg_cnt_nxt = 2'd1;
                    phase_nxt   = hvpss_pkg::PH_IDLE;
                    tick_nxt    = '0;
                  end
                end
                hvpss_pkg::PH_STOPWAIT: begin
                  tick_nxt = tick_inc;
                  if (tick_inc >= TW'(hvpss_pkg::STOP_DELAY_TICKS)) begin
                    duty_nxt    = '0;
                    charged_nxt = 1'b0;
                    relay_nxt   = 1'b0;
                    msg_nxt[0]  = hvpss_pkg::MSG_HV_OFF;
                    msg_nxt[1]  = hvpss_pkg::MSG_BLANK;
                    msg_cnt_nxt = 2'd2;
                    phase_nxt   = hvpss_pkg::PH_IDLE;
                    tick_nxt    = '0;
                  end
                end
                default: ;
              endcase
            end
            hvpss_pkg::MODE_START: begin
              if (phase_r == hvpss_pkg::PH_IDLE) begin
                if (charged_r) begin
                  status_nxt  = hvpss_pkg::ST_RUNNING;
                  pwm_nxt     = 1'b1;
                  msg_nxt[0]  = hvpss_pkg::MSG_READY;
                  msg_nxt[1]  = hvpss_pkg::MSG_BLANK;
                  msg_cnt_nxt = 2'd2;
                end else if (item.oil_ok) begin
                  status_nxt    = hvpss_pkg::ST_FAULTED;
                  msg_nxt[0]    = hvpss_pkg::MSG_CHECK_OIL;
                  msg_nxt[1]    = hvpss_pkg::MSG_ZERO_VOLTS;
                  msg_nxt[2]    = hvpss_pkg::MSG_PRECHARGE;
                  msg_cnt_nxt   = 2'd3;
                  volt_zero_nxt = item.volts;
                  ref_volts_nxt = item.volts;
                  relay_nxt     = 1'b1;
                  phase_nxt     = hvpss_pkg::PH_PRE;
                  tick_nxt      = '0;
                end else begin
                  status_nxt  = hvpss_pkg::ST_FAULTED;
                  msg_nxt[0]  = hvpss_pkg::MSG_CHECK_OIL;
                  msg_nxt[1]  = hvpss_pkg::MSG_OIL_FAULT;
                  msg_cnt_nxt = 2'd2;
                  phase_nxt   = hvpss_pkg::PH_FAILHOLD;
                  tick_nxt    = '0;
                end
              end
            end
            hvpss_pkg::MODE_STOP: begin
              if (phase_r != hvpss_pkg::PH_STOPWAIT) begin
                msg_nxt[0]  = hvpss_pkg::MSG_WAVE_OFF;
                msg_nxt[1]  = hvpss_pkg::MSG_OIL_OFF;
                msg_cnt_nxt = 2'd2;
                status_nxt  = hvpss_pkg::ST_STOPPED;
                pwm_nxt     = 1'b0;
                phase_nxt   = hvpss_pkg::PH_STOPWAIT;
                tick_nxt    = '0;
              end
            end
            hvpss_pkg::MODE_FAULT: begin
              status_nxt = hvpss_pkg::ST_FAULTED;
              pwm_nxt    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      hvpss_pkg::SQ_POST: begin
        rec_valid = 1'b1;
        if (rec_ready) begin
          sq_nxt = hvpss_pkg::SQ_EXEC;
          if (div_pend_r) begin
            cur_zero_nxt = quot;
          end
          div_pend_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r         <= hvpss_pkg::SQ_EXEC;
      phase_r      <= hvpss_pkg::PH_IDLE;
      status_r     <= hvpss_pkg::ST_STOPPED;
      tick_r       <= '0;
      charged_r    <= 1'b0;
      ref_volts_r  <= '0;
      prev_volts_r <= '0;
      sum_r        <= '0;
      volt_zero_r  <= '0;
      cur_zero_r   <= '0;
      duty_r       <= '0;
      relay_r      <= 1'b0;
      pwm_r        <= 1'b0;
      msg_cnt_r    <= '0;
      div_pend_r   <= 1'b0;
    end else begin
      sq_r         <= sq_nxt;
      phase_r      <= phase_nxt;
      status_r     <= status_nxt;
      tick_r       <= tick_nxt;
      charged_r    <= charged_nxt;
      ref_volts_r  <= ref_volts_nxt;
      prev_volts_r <= prev_volts_nxt;
      sum_r        <= sum_nxt;
      volt_zero_r  <= volt_zero_nxt;
      cur_zero_r   <= cur_zero_nxt;
      duty_r       <= duty_nxt;
      relay_r      <= relay_nxt;
      pwm_r        <= pwm_nxt;
      msg_cnt_r    <= msg_cnt_nxt;
      div_pend_r   <= div_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
  end

endmodule

/* rtl/hvpss_emit.sv */
module hvpss_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rec_valid,
  output logic                              rec_ready,
  input  hvpss_pkg::rec_t                   rec,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_run_status,
  output logic                              out_busy_res,
  output logic [hvpss_pkg::MSG_W-1:0]       out_message_code,
  output logic                              out_message_valid,
  output logic                              out_precharge_on,
  output logic [hvpss_pkg::DUTY_W-1:0]      out_contactor_duty,
  output logic                              out_pwm_enable,
  output logic [hvpss_pkg::VOLT_W-1:0]      out_volt_zero,
  output logic [hvpss_pkg::CUR_W-1:0]       out_current_zero,
  output logic                              out_last
);

  hvpss_pkg::rec_t                  rec_r;
  logic                             rec_valid_r, rec_valid_nxt;
  logic [hvpss_pkg::MSG_CNT_W-1:0]  idx_r, idx_nxt, last_idx;
  logic                             out_valid_r, out_valid_nxt;
  logic                             load, beat_last, has_msg;

  logic [1:0]                       status_r;
  logic                             busy_r, mvalid_r, relay_r, pwm_r, last_r;
  logic [hvpss_pkg::MSG_W-1:0]      code_r;
  logic [hvpss_pkg::DUTY_W-1:0]     duty_r;
  logic [hvpss_pkg::VOLT_W-1:0]     vz_r;
  logic [hvpss_pkg::CUR_W-1:0]      cz_r;

  assign rec_ready = !rec_valid_r;
  assign has_msg   = (rec_r.msg_count != '0);
  assign last_idx  = has_msg ? rec_r.msg_count - 1'b1 : '0;
  assign beat_last = (idx_r == last_idx);
  assign load      = rec_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    rec_valid_nxt = rec_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (beat_last) begin
        rec_valid_nxt = 1'b0;
        idx_nxt       = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (rec_valid && rec_ready) begin
      rec_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      rec_r <= rec;
    end
    if (load) begin
      status_r <= rec_r.status;
      busy_r   <= rec_r.busy;
      code_r   <= has_msg ? rec_r.msg_codes[idx_r] : hvpss_pkg::MSG_NONE;
      mvalid_r <= has_msg;
      relay_r  <= rec_r.relay;
      duty_r   <= rec_r.duty;
      pwm_r    <= rec_r.pwm;
      vz_r     <= rec_r.volt_zero;
      cz_r     <= rec_r.current_zero;
      last_r   <= beat_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_run_status     = status_r;
  assign out_busy_res       = busy_r;
  assign out_message_code   = code_r;
  assign out_message_valid  = mvalid_r;
  assign out_precharge_on   = relay_r;
  assign out_contactor_duty = duty_r;
  assign out_pwm_enable     = pwm_r;
  assign out_volt_zero      = vz_r;
  assign out_current_zero   = cz_r;
  assign out_last           = last_r;

endmodule

/* rtl/hv_precharge_start_sequencer_top.sv */
// channel   dir  handshake            payload
// in_       in   in_valid/in_ready    mode, bus_volts, bus_current, oil_switch_ok
// out_      out  out_valid/out_ready  run_status .. current_zero, last (1-3 beats/item)
// cfg_      in   cfg_we               cfg_index, cfg_wdata (no wait, no read-back)
//
// an item waits in the input queue, then the sequencer handles it in its exec
// state (state update) and its post state (zero-current multiply and hand-off,
// held until the record is taken), taking no new item meanwhile; the output
// stage sends 1-3 beats and frees its record in the cycle after the last beat
// is loaded; with the queue empty a first beat passes queue, exec, post, record
// reset is synchronous; config registers reset to their default values
// the queue keeps accepting until full while results stall at the output register
module hv_precharge_start_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = hvpss_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [hvpss_pkg::VOLT_W-1:0]      in_bus_volts,
  input  logic [hvpss_pkg::CUR_W-1:0]       in_bus_current,
  input  logic                              in_oil_switch_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_run_status,
  output logic                              out_busy_res,
  output logic [hvpss_pkg::MSG_W-1:0]       out_message_code,
  output logic                              out_message_valid,
  output logic                              out_precharge_on,
  output logic [hvpss_pkg::DUTY_W-1:0]      out_contactor_duty,
  output logic                              out_pwm_enable,
  output logic [hvpss_pkg::VOLT_W-1:0]      out_volt_zero,
  output logic [hvpss_pkg::CUR_W-1:0]       out_current_zero,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [hvpss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hvpss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic              q_valid, q_ready;
  hvpss_pkg::item_t  q_item;
  logic              rec_valid, rec_ready;
  hvpss_pkg::rec_t   rec;

  hvpss_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_bus_volts     (in_bus_volts),
    .in_bus_current   (in_bus_current),
    .in_oil_switch_ok (in_oil_switch_ok),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_item           (q_item)
  );

  hvpss_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec)
  );

  hvpss_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec_valid          (rec_valid),
    .rec_ready          (rec_ready),
    .rec                (rec),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_run_status     (out_run_status),
    .out_busy_res       (out_busy_res),
    .out_message_code   (out_message_code),
    .out_message_valid  (out_message_valid),
    .out_precharge_on   (out_precharge_on),
    .out_contactor_duty (out_contactor_duty),
    .out_pwm_enable     (out_pwm_enable),
    .out_volt_zero      (out_volt_zero),
    .out_current_zero   (out_current_zero),
    .out_last           (out_last)
  );

  // a result without a message is the only beat of its item
  a_no_msg_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_message_valid |-> out_last)
    else $error("message-less result not marked last");

  a_no_msg_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_message_valid |-> out_message_code == hvpss_pkg::MSG_NONE)
    else $error("message code set without message valid");

  // inverter waveform only runs in running status
  a_pwm_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pwm_enable |-> out_run_status == hvpss_pkg::ST_RUNNING)
    else $error("pwm enabled outside running status");

  a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec))
    else $error("sequencer record changed while stalled");

endmodule

/* tb/sv/hv_precharge_start_sequencer_top_tb.sv */
module hv_precharge_start_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hvpss_pkg::*;

  localparam int RANDOM_ITEMS = 80;
  localparam int DRAIN_LIMIT  = 20000;

  typedef struct {
    status_t           status;
    logic              busy;
    logic [MSG_W-1:0]  msg_code;
    logic              msg_valid;
    logic              relay;
    logic [DUTY_W-1:0] duty;
    logic              pwm;
    logic [VOLT_W-1:0] volt_zero;
    logic [CUR_W-1:0]  current_zero;
    logic              last;
  } seq_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_mode = MODE_TICK;
  logic [VOLT_W-1:0]     in_bus_volts = '0;
  logic [CUR_W-1:0]      in_bus_current = '0;
  logic                  in_oil_switch_ok = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_run_status;
  logic                  out_busy_res;
  logic [MSG_W-1:0]      out_message_code;
  logic                  out_message_valid;
  logic                  out_precharge_on;
  logic [DUTY_W-1:0]     out_contactor_duty;
  logic                  out_pwm_enable;
  logic [VOLT_W-1:0]     out_volt_zero;
  logic [CUR_W-1:0]      out_current_zero;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  hv_precharge_start_sequencer_top u_dut (.*);

  always #6 clk = ~clk;

  // sequencer image
  phase_t             seq_phase;
  logic [TICK_W-1:0]  tick_cnt;
  logic               charged;
  status_t            run_state;
  logic [VOLT_W-1:0]  ref_v;
  logic [VOLT_W-1:0]  prev_v;
  logic [VOLT_W-1:0]  vzero;
  logic [SUM_W-1:0]   cur_sum;
  logic [CUR_W-1:0]   czero;
  logic [DUTY_W-1:0]  duty;
  logic               relay;
  logic               pwm;

  logic [VOLT_W-1:0]  min_bus_cfg;
  logic [VOLT_W-1:0]  pre_rise_cfg;
  logic [VOLT_W-1:0]  settle_delta_cfg;
  logic [LIMIT_W-1:0] settle_limit_cfg;
  logic [DUTY_W-1:0]  pull_in_cfg;
  logic [DUTY_W-1:0]  hold_cfg;

  logic [MSG_W-1:0]   new_msgs[$];
  seq_beat_t          pending_beats[$];

  int send_idle_pct = 29;
  int recv_idle_pct = 83;
  int items_sent = 0;
  int beats_checked = 0;
  int mismatch_count = 0;
  int runs_reached = 0;
  int precharge_faults = 0;
  int oil_faults = 0;
  int settings_used = 0;

  function automatic logic [11:0] rand12();
    return 12'($urandom);
  endfunction

  function automatic logic rand1();
    return 1'($urandom);
  endfunction

  function automatic void reset_model();
    seq_phase = PH_IDLE;
    tick_cnt = '0;
    charged = 1'b0;
    run_state = ST_STOPPED;
    ref_v = '0;
    prev_v = '0;
    vzero = '0;
    cur_sum = '0;
    czero = '0;
    duty = '0;
    relay = 1'b0;
    pwm = 1'b0;
    min_bus_cfg = RST_MIN_BUS_VOLTS;
    pre_rise_cfg = RST_PRE_RISE_VOLTS;
    settle_delta_cfg = RST_SETTLE_DELTA;
    settle_limit_cfg = RST_SETTLE_LIMIT;
    pull_in_cfg = RST_PULL_IN_DUTY;
    hold_cfg = RST_HOLD_DUTY;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MIN_BUS_VOLTS:  min_bus_cfg = data;
      CFG_PRE_RISE_VOLTS: pre_rise_cfg = data;
      CFG_SETTLE_DELTA:   settle_delta_cfg = data;
      CFG_SETTLE_LIMIT:   settle_limit_cfg = data[LIMIT_W-1:0];
      CFG_PULL_IN_DUTY:   pull_in_cfg = data[DUTY_W-1:0];
      CFG_HOLD_DUTY:      hold_cfg = data[DUTY_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void announce(logic [MSG_W-1:0] code);
    if (new_msgs.size() < MSG_SLOTS) new_msgs.push_back(code);
  endfunction

  function automatic void trip_fault(logic [MSG_W-1:0] code);
    relay = 1'b0;
    duty = '0;
    run_state = ST_FAULTED;
    announce(code);
    seq_phase = PH_FAILHOLD;
    tick_cnt = '0;
    precharge_faults++;
  endfunction

  function automatic void begin_running();
    run_state = ST_RUNNING;
    pwm = 1'b1;
  endfunction

  function automatic void sequencer_tick(logic [VOLT_W-1:0] v, logic [CUR_W-1:0] cur);
    int diff;
    diff = 0;
    case (seq_phase)
      PH_PRE: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= PRE_TICKS) begin
          diff = int'(v) - int'(ref_v);
          if (diff > int'(pre_rise_cfg)) begin
            seq_phase = PH_SETTLE;
            tick_cnt = '0;
            prev_v = v;
          end else begin
            trip_fault(MSG_PRE_PRE_FAIL);
          end
        end
      end
      PH_SETTLE: begin
        diff = int'(v) - int'(prev_v);
        if (v > min_bus_cfg && diff < int'(settle_delta_cfg)) begin
          announce(MSG_HV_ON);
          duty = pull_in_cfg;
          seq_phase = PH_PULLIN;
          tick_cnt = '0;
        end else if (tick_cnt > settle_limit_cfg || tick_cnt >= TICK_MAX) begin
          trip_fault(MSG_PRE_FAIL);
        end else begin
          tick_cnt = tick_cnt + 1'b1;
          prev_v = v;
        end
      end
      PH_PULLIN: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= PULL_IN_TICKS) begin
          duty = hold_cfg;
          charged = 1'b1;
          relay = 1'b1;
          announce(MSG_ZERO_AMPS);
          seq_phase = PH_ZERO;
          tick_cnt = '0;
          cur_sum = '0;
        end
      end
      PH_ZERO: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt > ZERO_WAIT_TICKS) begin
          cur_sum = cur_sum + cur;
          if (tick_cnt >= ZERO_WAIT_TICKS + AVG_SAMPLES) begin
            czero = CUR_W'(cur_sum / AVG_SAMPLES);
            announce(MSG_ZERO_THROT);
            announce(MSG_WAVE_ON);
            begin_running();
            seq_phase = PH_ANNOUNCE;
            tick_cnt = '0;
            runs_reached++;
          end
        end
      end
      PH_ANNOUNCE: begin
        announce(MSG_READY);
        announce(MSG_BLANK);
        seq_phase = PH_IDLE;
        tick_cnt = '0;
      end
      PH_FAILHOLD: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= FAIL_HOLD_TICKS) begin
          announce(MSG_BLANK);
          seq_phase = PH_IDLE;
          tick_cnt = '0;
        end
      end
      PH_STOPWAIT: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= STOP_DELAY_TICKS) begin
          duty = '0;
          charged = 1'b0;
          relay = 1'b0;
          announce(MSG_HV_OFF);
          announce(MSG_BLANK);
          seq_phase = PH_IDLE;
          tick_cnt = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void sequencer_start(logic [VOLT_W-1:0] v, logic oil);
    if (seq_phase != PH_IDLE) return;
    if (charged) begin
      begin_running();
      announce(MSG_READY);
      announce(MSG_BLANK);
      return;
    end
    run_state = ST_FAULTED;
    announce(MSG_CHECK_OIL);
    if (oil) begin
      announce(MSG_ZERO_VOLTS);
      vzero = v;
      announce(MSG_PRECHARGE);
      ref_v = v;
      relay = 1'b1;
      seq_phase = PH_PRE;
    end else begin
      announce(MSG_OIL_FAULT);
      seq_phase = PH_FAILHOLD;
      oil_faults++;
    end
    tick_cnt = '0;
  endfunction

  function automatic void sequencer_stop();
    if (seq_phase == PH_STOPWAIT) return;
    announce(MSG_WAVE_OFF);
    run_state = ST_STOPPED;
    pwm = 1'b0;
    announce(MSG_OIL_OFF);
    seq_phase = PH_STOPWAIT;
    tick_cnt = '0;
  endfunction

  function automatic void step_sequencer(mode_t mode, logic [VOLT_W-1:0] v,
                                         logic [CUR_W-1:0] cur, logic oil);
    seq_beat_t beat;
    int n;
    new_msgs.delete();
    case (mode)
      MODE_TICK:  sequencer_tick(v, cur);
      MODE_START: sequencer_start(v, oil);
      MODE_STOP:  sequencer_stop();
      default: begin
        run_state = ST_FAULTED;
        pwm = 1'b0;
      end
    endcase
    n = (new_msgs.size() > 0) ? new_msgs.size() : 1;
    for (int k = 0; k < n; k++) begin
      beat.status = run_state;
      beat.busy = (seq_phase != PH_IDLE);
      beat.msg_valid = (new_msgs.size() > 0);
      beat.msg_code = beat.msg_valid ? new_msgs[k] : MSG_NONE;
      beat.relay = relay;
      beat.duty = duty;
      beat.pwm = pwm;
      beat.volt_zero = vzero;
      beat.current_zero = czero;
      beat.last = (k == n - 1);
      pending_beats.push_back(beat);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at beat %0d: %s got %0d expected %0d", beats_checked, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_beat();
    seq_beat_t want;
    if (pending_beats.size() == 0) begin
      report_mismatch("beat with nothing pending", 1, 0);
      return;
    end
    want = pending_beats.pop_front();
    if (out_run_status !== want.status) report_mismatch("run_status", out_run_status, want.status);
    if (out_busy_res !== want.busy) report_mismatch("busy_res", out_busy_res, want.busy);
    if (out_message_code !== want.msg_code)
      report_mismatch("message_code", out_message_code, want.msg_code);
    if (out_message_valid !== want.msg_valid)
      report_mismatch("message_valid", out_message_valid, want.msg_valid);
    if (out_precharge_on !== want.relay)
      report_mismatch("precharge_on", out_precharge_on, want.relay);
    if (out_contactor_duty !== want.duty)
      report_mismatch("contactor_duty", out_contactor_duty, want.duty);
    if (out_pwm_enable !== want.pwm) report_mismatch("pwm_enable", out_pwm_enable, want.pwm);
    if (out_volt_zero !== want.volt_zero)
      report_mismatch("volt_zero", out_volt_zero, want.volt_zero);
    if (out_current_zero !== want.current_zero)
      report_mismatch("current_zero", out_current_zero, want.current_zero);
    if (out_last !== want.last) report_mismatch("last", out_last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_beat();
      beats_checked++;
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // valid stays high on return so back-to-back beats need no second assignment
  task automatic send_item(mode_t mode, logic [VOLT_W-1:0] v, logic [CUR_W-1:0] cur,
                           logic oil);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_bus_volts <= v;
    in_bus_current <= cur;
    in_oil_switch_ok <= oil;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    step_sequencer(mode, v, cur, oil);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic write_config(logic [VOLT_W-1:0] min_v, logic [VOLT_W-1:0] rise_v,
                              logic [VOLT_W-1:0] delta_v, logic [LIMIT_W-1:0] limit_v,
                              logic [DUTY_W-1:0] pull_v, logic [DUTY_W-1:0] hold_v);
    put_reg(CFG_MIN_BUS_VOLTS, min_v);
    put_reg(CFG_PRE_RISE_VOLTS, rise_v);
    put_reg(CFG_SETTLE_DELTA, delta_v);
    put_reg(CFG_SETTLE_LIMIT, CFG_DATA_W'(limit_v));
    put_reg(CFG_PULL_IN_DUTY, CFG_DATA_W'(pull_v));
    put_reg(CFG_HOLD_DUTY, CFG_DATA_W'(hold_v));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic run_stop();
    int guard;
    guard = 0;
    send_item(MODE_STOP, rand12(), rand12(), rand1());
    while (seq_phase == PH_STOPWAIT && guard < 8) begin
      send_item(MODE_TICK, rand12(), rand12(), rand1());
      guard++;
    end
  endtask

  // mostly well-formed start; stall_settle keeps the bus low until the settle timeout
  task automatic run_cold_start(bit stall_settle);
    int guard;
    int lo;
    int hi;
    int r;
    logic [VOLT_W-1:0] v;
    guard = 0;
    if (stall_settle) send_item(MODE_START, 12'($urandom_range(3000, 0)), rand12(), 1'b1);
    else send_item(MODE_START, rand12(), rand12(), $urandom_range(9) != 0);
    while (seq_phase != PH_IDLE && guard < 300) begin
      v = rand12();
      case (seq_phase)
        PH_PRE: begin
          if (tick_cnt == PRE_TICKS - 1 && (stall_settle || $urandom_range(4) != 0)) begin
            lo = ref_v + pre_rise_cfg + 1;
            if (lo <= 4095) v = 12'($urandom_range(4095, lo));
          end
        end
        PH_SETTLE: begin
          if (stall_settle) begin
            v = '0;
          end else if ($urandom_range(2) == 0) begin
            lo = min_bus_cfg + 1;
            hi = prev_v + settle_delta_cfg - 1;
            if (hi > 4095) hi = 4095;
            if (lo <= hi) v = 12'($urandom_range(hi, lo));
          end else begin
            v = 12'($urandom_range(min_bus_cfg, 0));
          end
        end
        default: ;
      endcase
      r = stall_settle ? 99 : $urandom_range(99);
      if (r < 3) send_item(MODE_FAULT, rand12(), rand12(), rand1());
      else if (r < 5) send_item(MODE_START, rand12(), rand12(), rand1());
      else if (r < 6) send_item(MODE_STOP, rand12(), rand12(), rand1());
      else send_item(MODE_TICK, v, rand12(), rand1());
      guard++;
    end
  endtask

  task automatic test_directed_commands();
    send_item(MODE_FAULT, 12'hfff, 12'hfff, 1'b1);
    send_item(MODE_TICK, 12'h000, 12'h000, 1'b0);
    send_item(MODE_STOP, 12'h000, 12'hfff, 1'b0);
    // stop during the stop delay
    send_item(MODE_STOP, 12'hfff, 12'h000, 1'b1);
    send_item(MODE_TICK, 12'h555, 12'haaa, 1'b0);
    send_item(MODE_TICK, 12'haaa, 12'h555, 1'b1);
    // oil switch failing, then a start while busy, then a stop that aborts
    send_item(MODE_START, 12'h123, 12'h321, 1'b0);
    send_item(MODE_START, 12'h456, 12'h654, 1'b1);
    send_item(MODE_STOP, 12'h000, 12'h000, 1'b0);
    send_item(MODE_TICK, 12'h000, 12'h000, 1'b0);
    send_item(MODE_TICK, 12'h000, 12'h000, 1'b0);
    // bus falls during pre-precharge: negative rise
    send_item(MODE_START, 12'hfff, 12'hfff, 1'b1);
    repeat (PRE_TICKS) send_item(MODE_TICK, 12'h000, 12'hfff, 1'b1);
    send_item(MODE_STOP, 12'h000, 12'h000, 1'b1);
    repeat (STOP_DELAY_TICKS) send_item(MODE_TICK, 12'hfff, 12'h000, 1'b0);
  endtask

  task automatic test_config_extremes();
    hold_until_drained();
    write_config(RST_MIN_BUS_VOLTS, RST_PRE_RISE_VOLTS, RST_SETTLE_DELTA, RST_SETTLE_LIMIT,
                 RST_PULL_IN_DUTY, RST_HOLD_DUTY);
    run_cold_start(1'b0);
    // start with the bus already charged
    if (charged && seq_phase == PH_IDLE) send_item(MODE_START, rand12(), rand12(), 1'b1);
    run_stop();
    hold_until_drained();
    write_config('0, '0, '0, 7'd1, '0, '0);
    run_cold_start(1'b0);
    run_stop();
    // settle timeout with the limit at its top
    hold_until_drained();
    write_config('1, '0, '1, 7'd127, '1, '1);
    run_cold_start(1'b1);
    run_stop();
    hold_until_drained();
    write_config('1, '1, '1, 7'd127, '1, '1);
    run_cold_start(1'b0);
    run_stop();
  endtask

  task automatic test_random_traffic();
    int first_item;
    int r;
    bit switched;
    first_item = items_sent;
    switched = 1'b0;
    hold_until_drained();
    write_config(RST_MIN_BUS_VOLTS, RST_PRE_RISE_VOLTS, RST_SETTLE_DELTA, RST_SETTLE_LIMIT,
                 RST_PULL_IN_DUTY, RST_HOLD_DUTY);
    set_idling(83, 29);
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (!switched && items_sent - first_item >= RANDOM_ITEMS / 2) begin
        hold_until_drained();
        write_config(12'($urandom_range(3000, 1500)), 12'($urandom_range(900, 100)),
                     12'($urandom_range(300, 20)), 7'($urandom_range(80, 5)),
                     4'($urandom), 4'($urandom));
        set_idling(0, 0);
        switched = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 50) run_cold_start($urandom_range(11) == 0);
      else if (r < 60) run_stop();
      else if (r < 64) hold_until_drained();
      else if (r < 72 && charged && seq_phase == PH_IDLE)
        send_item(MODE_START, rand12(), rand12(), rand1());
      else send_item(mode_t'($urandom_range(3)), rand12(), rand12(), rand1());
    end
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_beats.size() != 0)
      report_mismatch("beats never delivered", 0, pending_beats.size());
    repeat (20) @(posedge clk);
    $display("run covered %0d input items and %0d result beats under %0d register settings",
             items_sent, beats_checked, settings_used);
    $display("starts reaching running: %0d, precharge faults: %0d, oil switch faults: %0d",
             runs_reached, precharge_faults, oil_faults);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  initial begin
    reset_model();
    set_idling(29, 83);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_commands();
    test_config_extremes();
    test_random_traffic();
    finish_run();
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* hv_precharge_start_sequencer_top.f */
rtl/hvpss_pkg.sv
rtl/hvpss_front.sv
rtl/hvpss_seq.sv
rtl/hvpss_emit.sv
rtl/hv_precharge_start_sequencer_top.sv
tb/sv/hv_precharge_start_sequencer_top_tb.sv
